// ===== rtl/bbtc_pkg.sv =====
package bbtc_pkg;

    // Cache geometry and field widths.
    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int SIZE_W   = 24;
    localparam int CMD_W    = 3;
    localparam int CAP_W    = 32;
    localparam int USED_W   = 30;
    localparam int BYTES_W  = SIZE_W + CNT_W;
    localparam int CMP_W    = (BYTES_W > CAP_W) ? BYTES_W : CAP_W;

    // Byte budget limits and reset value.
    localparam logic [CAP_W-1:0] MIN_CAPACITY = 32'd1048576;
    localparam logic [CAP_W-1:0] MAX_CAPACITY = 32'd1073741824;
    localparam logic [CAP_W-1:0] CAP_RESET    = 32'd268435456;

    // Configuration port decode.
    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND        = 3'd0,
        CMD_INSERT      = 3'd1,
        CMD_EVICT_OTHER = 3'd2,
        CMD_CLEAR       = 3'd3,
        CMD_FIT         = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        SCAN_LOCATE,
        SCAN_OLDEST,
        SCAN_OTHER
    } scan_mode_t;

    typedef enum logic [1:0] {
        ADJ_PROMOTE,
        ADJ_DROP,
        ADJ_SHIFT
    } adj_mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DROP,
        S_ADJ,
        S_POST,
        S_NEWWR,
        S_FIT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]    scale;
        logic [KEY_W-1:0]    tile;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
        logic [SLOT_W-1:0]   rank;
    } slot_t;

    typedef struct packed {
        scan_mode_t          scan_mode;
        adj_mode_t           adj_mode;
        logic [KEY_W-1:0]    scale;
        logic [KEY_W-1:0]    tile;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
        logic [SLOT_W-1:0]   rank;
        logic [SLOT_W-1:0]   target;
        logic                replace;
        logic [CNT_W-1:0]    live;
    } alu_ctl_t;

    typedef struct packed {
        logic  match;
        logic  oldest;
        slot_t upd;
    } alu_res_t;

    function automatic logic [USED_W-1:0] used_of(input logic [BYTES_W-1:0] b);
        logic [CMP_W-1:0] e;
        e = CMP_W'(b);
        return e[USED_W-1:0];
    endfunction

endpackage

// ===== rtl/bbtc_if.sv =====
interface bbtc_req_if;
    logic                             valid;
    logic                             ready;
    logic [bbtc_pkg::CMD_W-1:0]       command;
    logic signed [bbtc_pkg::KEY_W-1:0] scale_key;
    logic [bbtc_pkg::KEY_W-1:0]       tile_id;
    logic [bbtc_pkg::HANDLE_W-1:0]    buffer_handle;
    logic [bbtc_pkg::SIZE_W-1:0]      buffer_size;

    modport source (output valid, command, scale_key, tile_id, buffer_handle, buffer_size,
                    input ready);
    modport sink (input valid, command, scale_key, tile_id, buffer_handle, buffer_size,
                  output ready);
endinterface

interface bbtc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [bbtc_pkg::HANDLE_W-1:0] found_handle;
    logic [bbtc_pkg::USED_W-1:0]   used_bytes;
    logic [bbtc_pkg::CNT_W-1:0]    entry_count;
    logic [31:0]                   hit_count;
    logic [31:0]                   miss_count;
    logic [31:0]                   eviction_count;

    modport source (output valid, hit, found_handle, used_bytes, entry_count, hit_count,
                    miss_count, eviction_count, input ready);
    modport sink (input valid, hit, found_handle, used_bytes, entry_count, hit_count,
                  miss_count, eviction_count, output ready);
endinterface

// ===== rtl/bbtc_cfg.sv =====
module bbtc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bbtc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [bbtc_pkg::CAP_W-1:0]        capacity
);

    logic [bbtc_pkg::CAP_W-1:0] capacity_reg;
    logic [bbtc_pkg::CAP_W-1:0] capacity_next;
    logic                       wr_hit;
    logic                       sel_cap;

    assign sel_cap = (paddr[bbtc_pkg::APB_ADDR_W-1:2] == bbtc_pkg::REG_CAPACITY);
    assign wr_hit  = psel && penable && pwrite && sel_cap;

    // Clamp to the floor first, then the ceiling, so the ceiling wins on a conflict.
    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_hit)
        begin
            capacity_next = pwdata;
            if (capacity_next < bbtc_pkg::MIN_CAPACITY)
            begin
                capacity_next = bbtc_pkg::MIN_CAPACITY;
            end
            if (capacity_next > bbtc_pkg::MAX_CAPACITY)
            begin
                capacity_next = bbtc_pkg::MAX_CAPACITY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bbtc_pkg::CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign prdata   = sel_cap ? capacity_reg : 32'd0;
    assign pready   = 1'b1;
    assign capacity = capacity_reg;

endmodule

// ===== rtl/bbtc_slot_alu.sv =====
module bbtc_slot_alu (
    input  bbtc_pkg::alu_ctl_t          ctl,
    input  logic [bbtc_pkg::SLOT_W-1:0] idx,
    input  logic                        vld,
    input  bbtc_pkg::slot_t             cur,
    output bbtc_pkg::alu_res_t          res
);

    logic key_eq;
    logic scale_eq;
    logic is_oldest;

    assign scale_eq  = (cur.scale == ctl.scale);
    assign key_eq    = vld && scale_eq && (cur.tile == ctl.tile);
    assign is_oldest = vld &&
                       ((bbtc_pkg::CNT_W'(cur.rank) + bbtc_pkg::CNT_W'(1)) == ctl.live);

    always_comb
    begin
        res.oldest = is_oldest;
        case (ctl.scan_mode)
            bbtc_pkg::SCAN_LOCATE: res.match = key_eq;
            bbtc_pkg::SCAN_OLDEST: res.match = is_oldest;
            bbtc_pkg::SCAN_OTHER:  res.match = vld && !scale_eq;
            default:               res.match = 1'b0;
        endcase

        // Rank update for the entry passing through the sweep.
        res.upd = cur;
        case (ctl.adj_mode)
            bbtc_pkg::ADJ_PROMOTE:
            begin
                if (idx == ctl.target)
                begin
                    res.upd.rank = '0;
                    if (ctl.replace)
                    begin
                        res.upd.handle = ctl.handle;
                        res.upd.size   = ctl.size;
                    end
                end
                else if (vld && (cur.rank < ctl.rank))
                begin
                    res.upd.rank = cur.rank + bbtc_pkg::SLOT_W'(1);
                end
            end
            bbtc_pkg::ADJ_DROP:
            begin
                if (vld && (cur.rank > ctl.rank))
                begin
                    res.upd.rank = cur.rank - bbtc_pkg::SLOT_W'(1);
                end
            end
            bbtc_pkg::ADJ_SHIFT:
            begin
                if (vld)
                begin
                    res.upd.rank = cur.rank + bbtc_pkg::SLOT_W'(1);
                end
            end
            default:
            begin
                res.upd = cur;
            end
        endcase
    end

endmodule

// ===== rtl/bbtc_engine.sv =====
module bbtc_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    bbtc_req_if.sink                   req,
    bbtc_rsp_if.source                 rsp,
    input  logic [bbtc_pkg::CAP_W-1:0] capacity
);

    localparam int SW = bbtc_pkg::SLOT_W;
    localparam int CW = bbtc_pkg::CNT_W;
    localparam int BW = bbtc_pkg::BYTES_W;

    // Slot record store, one read and one write port, registered read.
    bbtc_pkg::slot_t mem [bbtc_pkg::SLOTS];
    bbtc_pkg::slot_t rdata_reg;
    logic [SW-1:0]   mem_raddr;
    logic            mem_we;
    logic [SW-1:0]   mem_waddr;
    bbtc_pkg::slot_t mem_wdata;

    bbtc_pkg::state_t state_reg, state_next;
    bbtc_pkg::cmd_t   cmd_reg;
    logic [bbtc_pkg::KEY_W-1:0]    scale_reg, tile_reg;
    logic [bbtc_pkg::HANDLE_W-1:0] handle_reg;
    logic [bbtc_pkg::SIZE_W-1:0]   size_reg;
    logic                          new_done_reg;

    logic [bbtc_pkg::SLOTS-1:0] valid_reg;
    logic [BW-1:0]              bytes_reg;
    logic [CW-1:0]              live_reg;
    logic [31:0]                hits_reg, misses_reg, evict_reg;

    // Sweep sequencer.
    logic [CW-1:0] cnt_reg;
    logic          pipe_vld_reg;
    logic [SW-1:0] pidx_reg;
    logic          sweep_on, issue, sweep_done, sweep_enter;

    // Scan captures.
    logic                          found_reg, old_found_reg, free_found_reg;
    logic [SW-1:0]                 found_idx_reg, old_idx_reg, free_idx_reg;
    logic [SW-1:0]                 found_rank_reg, old_rank_reg;
    logic [bbtc_pkg::SIZE_W-1:0]   found_size_reg, old_size_reg;
    logic [bbtc_pkg::HANDLE_W-1:0] found_handle_reg;

    // Rank sweep setup.
    bbtc_pkg::adj_mode_t adj_mode_reg, adj_mode_next;
    logic [SW-1:0]       adj_rank_reg, adj_rank_next;
    logic [SW-1:0]       adj_target_reg, adj_target_next;
    logic                adj_replace_reg, adj_replace_next;

    // Result of the current request and the output register.
    logic                          res_hit_reg;
    logic [bbtc_pkg::HANDLE_W-1:0] res_handle_reg;
    logic                          out_valid_reg;
    logic                          out_hit_reg;
    logic [bbtc_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [bbtc_pkg::USED_W-1:0]   out_used_reg;
    logic [CW-1:0]                 out_count_reg;
    logic [31:0]                   out_hits_reg, out_misses_reg, out_evict_reg;

    bbtc_pkg::alu_ctl_t   alu_ctl;
    bbtc_pkg::alu_res_t   alu_res;
    bbtc_pkg::scan_mode_t scan_mode;
    logic                 cur_vld;
    logic                 full, over_budget;
    logic [SW-1:0]        vic_idx, vic_rank, new_idx;
    logic [bbtc_pkg::SIZE_W-1:0] vic_size;
    logic                 rsp_free;

    assign sweep_on    = (state_reg == bbtc_pkg::S_SCAN) || (state_reg == bbtc_pkg::S_ADJ);
    assign issue       = sweep_on && (cnt_reg < CW'(bbtc_pkg::SLOTS));
    assign sweep_done  = sweep_on && (cnt_reg == CW'(bbtc_pkg::SLOTS)) && !pipe_vld_reg;
    assign sweep_enter = (state_next != state_reg) &&
                         ((state_next == bbtc_pkg::S_SCAN) || (state_next == bbtc_pkg::S_ADJ));

    assign cur_vld     = valid_reg[pidx_reg];
    assign full        = (live_reg == CW'(bbtc_pkg::SLOTS));
    assign over_budget = (bbtc_pkg::CMP_W'(bytes_reg) > bbtc_pkg::CMP_W'(capacity));
    assign rsp_free    = !out_valid_reg || rsp.ready;

    // Evict-other drops the matched slot; every other drop takes the oldest.
    assign vic_idx  = (cmd_reg == bbtc_pkg::CMD_EVICT_OTHER) ? found_idx_reg  : old_idx_reg;
    assign vic_rank = (cmd_reg == bbtc_pkg::CMD_EVICT_OTHER) ? found_rank_reg : old_rank_reg;
    assign vic_size = (cmd_reg == bbtc_pkg::CMD_EVICT_OTHER) ? found_size_reg : old_size_reg;
    // With a full cache no slot is free and the dropped oldest slot is reused.
    assign new_idx  = free_found_reg ? free_idx_reg : old_idx_reg;

    always_comb
    begin
        if (cmd_reg == bbtc_pkg::CMD_EVICT_OTHER)
        begin
            scan_mode = bbtc_pkg::SCAN_OTHER;
        end
        else if ((cmd_reg == bbtc_pkg::CMD_FIND) ||
                 ((cmd_reg == bbtc_pkg::CMD_INSERT) && !new_done_reg))
        begin
            scan_mode = bbtc_pkg::SCAN_LOCATE;
        end
        else
        begin
            scan_mode = bbtc_pkg::SCAN_OLDEST;
        end
    end

    always_comb
    begin
        alu_ctl.scan_mode = scan_mode;
        alu_ctl.adj_mode  = adj_mode_reg;
        alu_ctl.scale     = scale_reg;
        alu_ctl.tile      = tile_reg;
        alu_ctl.handle    = handle_reg;
        alu_ctl.size      = size_reg;
        alu_ctl.rank      = adj_rank_reg;
        alu_ctl.target    = adj_target_reg;
        alu_ctl.replace   = adj_replace_reg;
        alu_ctl.live      = live_reg;
    end

    bbtc_slot_alu u_alu (
        .ctl (alu_ctl),
        .idx (pidx_reg),
        .vld (cur_vld),
        .cur (rdata_reg),
        .res (alu_res)
    );

    // Next state and rank sweep setup.
    always_comb
    begin
        state_next       = state_reg;
        adj_mode_next    = adj_mode_reg;
        adj_rank_next    = adj_rank_reg;
        adj_target_next  = adj_target_reg;
        adj_replace_next = adj_replace_reg;
        case (state_reg)
            bbtc_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    case (bbtc_pkg::cmd_t'(req.command))
                        bbtc_pkg::CMD_FIND:        state_next = bbtc_pkg::S_SCAN;
                        bbtc_pkg::CMD_INSERT:
                        begin
                            if (req.buffer_handle == '0)
                            begin
                                state_next = bbtc_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = bbtc_pkg::S_SCAN;
                            end
                        end
                        bbtc_pkg::CMD_EVICT_OTHER: state_next = bbtc_pkg::S_SCAN;
                        bbtc_pkg::CMD_FIT:         state_next = bbtc_pkg::S_FIT;
                        default:                   state_next = bbtc_pkg::S_RESP;
                    endcase
                end
            end
            bbtc_pkg::S_SCAN:
            begin
                if (sweep_done)
                begin
                    state_next = bbtc_pkg::S_DECIDE;
                end
            end
            bbtc_pkg::S_DECIDE:
            begin
                case (cmd_reg)
                    bbtc_pkg::CMD_FIND, bbtc_pkg::CMD_INSERT:
                    begin
                        if ((cmd_reg == bbtc_pkg::CMD_INSERT) && new_done_reg)
                        begin
                            state_next = old_found_reg ? bbtc_pkg::S_DROP : bbtc_pkg::S_RESP;
                        end
                        else if (found_reg)
                        begin
                            state_next       = bbtc_pkg::S_ADJ;
                            adj_mode_next    = bbtc_pkg::ADJ_PROMOTE;
                            adj_rank_next    = found_rank_reg;
                            adj_target_next  = found_idx_reg;
                            adj_replace_next = (cmd_reg == bbtc_pkg::CMD_INSERT);
                        end
                        else if (cmd_reg == bbtc_pkg::CMD_FIND)
                        begin
                            state_next = bbtc_pkg::S_RESP;
                        end
                        else if (full)
                        begin
                            state_next = bbtc_pkg::S_DROP;
                        end
                        else
                        begin
                            state_next    = bbtc_pkg::S_ADJ;
                            adj_mode_next = bbtc_pkg::ADJ_SHIFT;
                        end
                    end
                    bbtc_pkg::CMD_EVICT_OTHER:
                    begin
                        state_next = found_reg ? bbtc_pkg::S_DROP : bbtc_pkg::S_RESP;
                    end
                    bbtc_pkg::CMD_FIT:
                    begin
                        state_next = old_found_reg ? bbtc_pkg::S_DROP : bbtc_pkg::S_RESP;
                    end
                    default:
                    begin
                        state_next = bbtc_pkg::S_RESP;
                    end
                endcase
            end
            bbtc_pkg::S_DROP:
            begin
                state_next    = bbtc_pkg::S_ADJ;
                adj_mode_next = bbtc_pkg::ADJ_DROP;
                adj_rank_next = vic_rank;
            end
            bbtc_pkg::S_ADJ:
            begin
                if (sweep_done)
                begin
                    state_next = bbtc_pkg::S_POST;
                end
            end
            bbtc_pkg::S_POST:
            begin
                case (adj_mode_reg)
                    bbtc_pkg::ADJ_PROMOTE: state_next = bbtc_pkg::S_RESP;
                    bbtc_pkg::ADJ_SHIFT:   state_next = bbtc_pkg::S_NEWWR;
                    default:
                    begin
                        if (cmd_reg == bbtc_pkg::CMD_EVICT_OTHER)
                        begin
                            state_next = bbtc_pkg::S_SCAN;
                        end
                        else if ((cmd_reg == bbtc_pkg::CMD_INSERT) && !new_done_reg)
                        begin
                            state_next    = bbtc_pkg::S_ADJ;
                            adj_mode_next = bbtc_pkg::ADJ_SHIFT;
                        end
                        else
                        begin
                            state_next = bbtc_pkg::S_FIT;
                        end
                    end
                endcase
            end
            bbtc_pkg::S_NEWWR:
            begin
                state_next = bbtc_pkg::S_FIT;
            end
            bbtc_pkg::S_FIT:
            begin
                if (over_budget && (live_reg > CW'(1)))
                begin
                    state_next = bbtc_pkg::S_SCAN;
                end
                else
                begin
                    state_next = bbtc_pkg::S_RESP;
                end
            end
            bbtc_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = bbtc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bbtc_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        mem_raddr = cnt_reg[SW-1:0];
        mem_we    = 1'b0;
        mem_waddr = pidx_reg;
        mem_wdata = alu_res.upd;
        case (state_reg)
            bbtc_pkg::S_ADJ:
            begin
                mem_we = pipe_vld_reg;
            end
            bbtc_pkg::S_NEWWR:
            begin
                mem_we           = 1'b1;
                mem_waddr        = new_idx;
                mem_wdata.scale  = scale_reg;
                mem_wdata.tile   = tile_reg;
                mem_wdata.handle = handle_reg;
                mem_wdata.size   = size_reg;
                mem_wdata.rank   = '0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Request payload, scan captures and sweep setup carry no reset.
    always_ff @(posedge clk)
    begin
        pidx_reg        <= cnt_reg[SW-1:0];
        adj_mode_reg    <= adj_mode_next;
        adj_rank_reg    <= adj_rank_next;
        adj_target_reg  <= adj_target_next;
        adj_replace_reg <= adj_replace_next;
        if ((state_reg == bbtc_pkg::S_IDLE) && req.valid)
        begin
            scale_reg  <= req.scale_key;
            tile_reg   <= req.tile_id;
            handle_reg <= req.buffer_handle;
            size_reg   <= req.buffer_size;
        end
        if ((state_reg == bbtc_pkg::S_SCAN) && pipe_vld_reg)
        begin
            if (!found_reg && alu_res.match)
            begin
                found_idx_reg    <= pidx_reg;
                found_rank_reg   <= rdata_reg.rank;
                found_size_reg   <= rdata_reg.size;
                found_handle_reg <= rdata_reg.handle;
            end
            if (!old_found_reg && alu_res.oldest)
            begin
                old_idx_reg  <= pidx_reg;
                old_rank_reg <= rdata_reg.rank;
                old_size_reg <= rdata_reg.size;
            end
            if (!free_found_reg && !cur_vld)
            begin
                free_idx_reg <= pidx_reg;
            end
        end
        if ((state_reg == bbtc_pkg::S_RESP) && rsp_free)
        begin
            out_hit_reg    <= res_hit_reg;
            out_handle_reg <= res_handle_reg;
            out_used_reg   <= bbtc_pkg::used_of(bytes_reg);
            out_count_reg  <= live_reg;
            out_hits_reg   <= hits_reg;
            out_misses_reg <= misses_reg;
            out_evict_reg  <= evict_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bbtc_pkg::S_IDLE;
            cmd_reg        <= bbtc_pkg::CMD_FIND;
            new_done_reg   <= 1'b0;
            valid_reg      <= '0;
            bytes_reg      <= '0;
            live_reg       <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evict_reg      <= '0;
            cnt_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            old_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            res_hit_reg    <= 1'b0;
            res_handle_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pipe_vld_reg <= issue;

            if (sweep_enter)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end

            if (sweep_enter && (state_next == bbtc_pkg::S_SCAN))
            begin
                found_reg      <= 1'b0;
                old_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if ((state_reg == bbtc_pkg::S_SCAN) && pipe_vld_reg)
            begin
                found_reg      <= found_reg || alu_res.match;
                old_found_reg  <= old_found_reg || alu_res.oldest;
                free_found_reg <= free_found_reg || !cur_vld;
            end

            // A finished request loads the output register; otherwise a taken result clears it.
            if ((state_reg == bbtc_pkg::S_RESP) && rsp_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                bbtc_pkg::S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg        <= bbtc_pkg::cmd_t'(req.command);
                        new_done_reg   <= 1'b0;
                        res_hit_reg    <= 1'b0;
                        res_handle_reg <= '0;
                        if (bbtc_pkg::cmd_t'(req.command) == bbtc_pkg::CMD_CLEAR)
                        begin
                            valid_reg <= '0;
                            bytes_reg <= '0;
                            live_reg  <= '0;
                        end
                    end
                end
                bbtc_pkg::S_DECIDE:
                begin
                    if (cmd_reg == bbtc_pkg::CMD_FIND)
                    begin
                        if (found_reg)
                        begin
                            hits_reg       <= hits_reg + 32'd1;
                            res_hit_reg    <= 1'b1;
                            res_handle_reg <= found_handle_reg;
                        end
                        else
                        begin
                            misses_reg <= misses_reg + 32'd1;
                        end
                    end
                    else if ((cmd_reg == bbtc_pkg::CMD_INSERT) && !new_done_reg && found_reg)
                    begin
                        bytes_reg <= bytes_reg - BW'(found_size_reg) + BW'(size_reg);
                    end
                end
                bbtc_pkg::S_DROP:
                begin
                    valid_reg[vic_idx] <= 1'b0;
                    bytes_reg          <= bytes_reg - BW'(vic_size);
                    live_reg           <= live_reg - CW'(1);
                    evict_reg          <= evict_reg + 32'd1;
                end
                bbtc_pkg::S_NEWWR:
                begin
                    valid_reg[new_idx] <= 1'b1;
                    bytes_reg          <= bytes_reg + BW'(size_reg);
                    live_reg           <= live_reg + CW'(1);
                    new_done_reg       <= 1'b1;
                end
                default:
                begin
                    new_done_reg <= new_done_reg;
                end
            endcase
        end
    end

    assign req.ready          = (state_reg == bbtc_pkg::S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.found_handle   = out_handle_reg;
    assign rsp.used_bytes     = out_used_reg;
    assign rsp.entry_count    = out_count_reg;
    assign rsp.hit_count      = out_hits_reg;
    assign rsp.miss_count     = out_misses_reg;
    assign rsp.eviction_count = out_evict_reg;

`ifndef SYNTH
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(bbtc_pkg::SLOTS))
        else $error("entry count exceeds the slot count");

    a_valid_pop: assert property (@(posedge clk) disable iff (!rst_n)
        CW'($countones(valid_reg)) == live_reg)
        else $error("valid bits disagree with the entry count");

    a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg == '0) |-> (bytes_reg == '0))
        else $error("bytes in use while the cache is empty");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(bbtc_pkg::SLOTS))
        else $error("sweep counter ran past the last slot");

    a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == bbtc_pkg::S_RESP) && (state_next == bbtc_pkg::S_IDLE))
        |=> out_valid_reg)
        else $error("finished request did not reach the output register");
`endif

endmodule

// ===== rtl/byte_budget_lru_tile_cache_core.sv =====
// Each request runs as a series of slot sweeps: clear and an insert with a null handle need
// none; find takes 1 or 2 sweeps, insert 2 to 3 sweeps plus 2 sweeps per budget eviction.
// Requests are handled one at a time; the next is taken once the current one has finished.
// Reset: rst_n is asynchronous and active low; it empties the cache, zeroes all counters
// and sets the byte budget to 268435456. Slot records are not cleared, only their valid bits.
//
// The cache keeps 64 slot records (key, handle, size, recency rank) in a memory with one
// read and one write port and a registered read. All searching and rank bookkeeping runs
// through one shared slot unit that looks at one record per cycle while a small sequencer
// sweeps the slot index from 0 to 63. A scan sweep locates a key, the oldest entry, the
// first free slot, or an entry of another scale. A rank sweep then rewrites every record:
// promoting an entry, closing the gap left by an evicted entry, or ageing all entries
// to make room for a new one at the front.
//
// Valid bits, the byte total, the entry count and the counters live in flip-flops.
// Every finished request is copied into an output register, so the result waits there
// while the engine takes the next request. The byte budget sits in an APB register,
// clamped on write; it takes effect on the next fit command or insert of a new key.
module byte_budget_lru_tile_cache_core (
    input  logic                            clk,
    input  logic                            rst_n,
    bbtc_req_if.sink                        req,
    bbtc_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bbtc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // Current byte budget as seen by the eviction logic.
    logic [bbtc_pkg::CAP_W-1:0] capacity;

    bbtc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // The engine owns the slot memory, the sweep sequencer and the status counters.
    bbtc_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .capacity (capacity)
    );

endmodule
